>>> rtl/mft_pkg.sv
package mft_pkg;

  localparam int unsigned HDR_PAIRS    = 20;
  localparam int unsigned HDR_SEGMENTS = 2 * HDR_PAIRS + 3;
  localparam int unsigned DATA_BITS    = 43;
  localparam int unsigned SEG_W        = 6;
  localparam int unsigned TICK_W       = 4;
  localparam int unsigned BIT_W        = 6;

  localparam logic [TICK_W-1:0] SHORT_TICKS  = 4'd2;
  localparam logic [TICK_W-1:0] LONG_TICKS   = 4'd8;
  localparam logic [7:0]        CHECK_OFFSET = 8'd3;

  localparam logic [SEG_W-1:0] LAST_SEG     = SEG_W'(HDR_SEGMENTS - 1);
  localparam logic [SEG_W-1:0] LONG_HIGH_SEG = SEG_W'(2 * HDR_PAIRS + 1);
  localparam logic [SEG_W-1:0] SHORT_END_SEG = SEG_W'(2 * HDR_PAIRS);
  localparam logic [BIT_W-1:0] LAST_BIT     = BIT_W'(DATA_BITS - 1);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SEND = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_DATA
  } phase_t;

  // One decoded transaction as it travels from the front to the back.
  typedef struct packed {
    logic                 is_send;
    logic [DATA_BITS-1:0] frame_bits;
  } cmd_t;

  function automatic logic header_level(input logic [SEG_W-1:0] seg);
    logic lvl;
    if (seg < SHORT_END_SEG) begin
      lvl = seg[0];
    end else if (seg == LONG_HIGH_SEG) begin
      lvl = 1'b1;
    end else begin
      lvl = 1'b0;
    end
    return lvl;
  endfunction

  function automatic logic [TICK_W-1:0] header_length(input logic [SEG_W-1:0] seg);
    return (seg <= SHORT_END_SEG) ? SHORT_TICKS : LONG_TICKS;
  endfunction

endpackage

>>> rtl/mft_front.sv
module mft_front
  import mft_pkg::*;
(
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [15:0] in_remote_id,
  input  logic [7:0]  in_channel_number,
  input  logic [7:0]  in_action_code,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  logic [7:0] remote_lo;
  logic [7:0] remote_hi;
  logic [7:0] checksum;

  assign remote_lo = in_remote_id[7:0];
  assign remote_hi = in_remote_id[15:8];
  assign checksum  = in_channel_number + remote_lo + remote_hi + in_action_code
                     + CHECK_OFFSET;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.is_send    = (opcode_t'(in_opcode) == OP_SEND);
    // Leading zero bit, five bytes, then two trailing zero bits.
    q_cmd.frame_bits = {2'b00, checksum, in_action_code, remote_hi, remote_lo,
                        in_channel_number, 1'b0};
  end

endmodule

>>> rtl/mft_queue.sv
module mft_queue
  import mft_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t              entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> rtl/mft_back.sv
module mft_back
  import mft_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic head_valid,
  input  cmd_t head_cmd,
  output logic pop,
  output logic out_valid,
  input  logic out_stall,
  output logic out_line_level,
  output logic out_busy_res,
  output logic out_accepted,
  output logic out_frame_done
);

  phase_t               phase_r;
  phase_t               phase_nxt;
  logic [DATA_BITS-1:0] frame_bits_r;
  logic [DATA_BITS-1:0] frame_bits_nxt;
  logic [SEG_W-1:0]     segment_r;
  logic [SEG_W-1:0]     segment_nxt;
  logic [TICK_W-1:0]    tick_r;
  logic [TICK_W-1:0]    tick_nxt;
  logic [BIT_W-1:0]     bit_idx_r;
  logic [BIT_W-1:0]     bit_idx_nxt;
  logic                 half_r;
  logic                 half_nxt;
  logic                 held_r;
  logic                 held_nxt;

  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic                 line_r;
  logic                 line_nxt;
  logic                 busy_r;
  logic                 busy_nxt;
  logic                 acc_r;
  logic                 acc_nxt;
  logic                 done_r;
  logic                 done_nxt;

  logic [SEG_W-1:0]     seg;
  logic [SEG_W-1:0]     seg_inc;
  logic [TICK_W-1:0]    tick_inc;
  logic [BIT_W-1:0]     idx;
  logic [BIT_W-1:0]     idx_inc;
  logic                 data_bit;
  logic                 level;

  // The output register is free when empty or being drained this cycle.
  assign pop = head_valid && (!out_valid_r || !out_stall);

  assign out_valid      = out_valid_r;
  assign out_line_level = line_r;
  assign out_busy_res   = busy_r;
  assign out_accepted   = acc_r;
  assign out_frame_done = done_r;

  always_comb begin
    phase_nxt      = phase_r;
    frame_bits_nxt = frame_bits_r;
    segment_nxt    = segment_r;
    tick_nxt       = tick_r;
    bit_idx_nxt    = bit_idx_r;
    half_nxt       = half_r;
    held_nxt       = held_r;
    acc_nxt        = 1'b0;
    done_nxt       = 1'b0;
    level          = held_r;

    seg      = (segment_r > LAST_SEG) ? LAST_SEG : segment_r;
    seg_inc  = seg + 1'b1;
    tick_inc = tick_r + 1'b1;
    idx      = (bit_idx_r > LAST_BIT) ? LAST_BIT : bit_idx_r;
    idx_inc  = idx + 1'b1;
    data_bit = frame_bits_r[idx];

    if (head_cmd.is_send) begin
      if (phase_r == PH_IDLE) begin
        frame_bits_nxt = head_cmd.frame_bits;
        segment_nxt    = '0;
        tick_nxt       = '0;
        bit_idx_nxt    = '0;
        half_nxt       = 1'b0;
        phase_nxt      = PH_HEADER;
        acc_nxt        = 1'b1;
      end
    end else begin
      case (phase_r)
        PH_IDLE: begin
        end
        PH_HEADER: begin
          level = header_level(seg);
          if (tick_inc >= header_length(seg)) begin
            tick_nxt = '0;
            if (seg_inc > LAST_SEG) begin
              segment_nxt = '0;
              phase_nxt   = PH_DATA;
              bit_idx_nxt = '0;
              half_nxt    = 1'b0;
            end else begin
              segment_nxt = seg_inc;
            end
          end else begin
            tick_nxt = tick_inc;
          end
          held_nxt = level;
        end
        PH_DATA: begin
          // Manchester: a one goes low then high, a zero high then low.
          level = half_r ? data_bit : ~data_bit;
          if (!half_r) begin
            half_nxt = 1'b1;
          end else begin
            half_nxt = 1'b0;
            if (idx_inc > LAST_BIT) begin
              bit_idx_nxt = '0;
              phase_nxt   = PH_IDLE;
              done_nxt    = 1'b1;
            end else begin
              bit_idx_nxt = idx_inc;
            end
          end
          held_nxt = level;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    line_nxt      = level;
    busy_nxt      = (phase_nxt != PH_IDLE);
    out_valid_nxt = pop ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      frame_bits_r <= '0;
      segment_r    <= '0;
      tick_r       <= '0;
      bit_idx_r    <= '0;
      half_r       <= 1'b0;
      held_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        phase_r      <= phase_nxt;
        frame_bits_r <= frame_bits_nxt;
        segment_r    <= segment_nxt;
        tick_r       <= tick_nxt;
        bit_idx_r    <= bit_idx_nxt;
        half_r       <= half_nxt;
        held_r       <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      line_r <= line_nxt;
      busy_r <= busy_nxt;
      acc_r  <= acc_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

>>> rtl/manchester_frame_transmitter.sv
// Results are registered; the waveform engine steps once per tick.
// Throughput: one transaction per cycle while out_stall is low.
// A two-entry command queue lets the input side keep taking transactions
// while a result waits on out_stall; the input stalls only when it is full.
// Reset (rst_n low at a clock edge) empties the queue, ends any frame in
// progress and clears the held line level; out_line_level is not reset.
module manchester_frame_transmitter
  import mft_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [15:0] in_remote_id,
  input  logic [7:0]  in_channel_number,
  input  logic [7:0]  in_action_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_line_level,
  output logic        out_busy_res,
  output logic        out_accepted,
  output logic        out_frame_done
);

  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic q_pop;
  logic head_valid;
  cmd_t head_cmd;

  mft_front u_front (
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_remote_id      (in_remote_id),
    .in_channel_number (in_channel_number),
    .in_action_code    (in_action_code),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_cmd             (q_cmd)
  );

  mft_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  mft_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_cmd       (head_cmd),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_line_level (out_line_level),
    .out_busy_res   (out_busy_res),
    .out_accepted   (out_accepted),
    .out_frame_done (out_frame_done)
  );

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
  import mft_pkg::*;

  // One frame: the header segments plus two ticks for every data bit.
  localparam int FRAME_TICKS = 2 * HDR_PAIRS * 2 + 2 + 8 + 8 + 2 * DATA_BITS;
  localparam int RANDOM_ITEMS = 212;
  localparam int LONG_HOLD = 200;
  localparam int HOLD_AT_RESULT = 300;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic level;
    logic busy;
    logic acc;
    logic done;
  } tx_result_t;

  localparam tx_result_t R_IDLE    = '{1'b0, 1'b0, 1'b0, 1'b0};
  localparam tx_result_t R_TAKEN   = '{1'b0, 1'b1, 1'b1, 1'b0};
  localparam tx_result_t R_REFUSED = '{1'b0, 1'b1, 1'b0, 1'b0};
  localparam tx_result_t R_LAST    = '{1'b0, 1'b0, 1'b0, 1'b1};

  typedef struct {
    opcode_t     op;
    logic [15:0] rem;
    logic [7:0]  ch;
    logic [7:0]  act;
    int          reps;
    bit          typed;
    tx_result_t  want;
  } stim_row_t;

  // Rows without a typed result are checked against the line predictor.
  stim_row_t plan [6] = '{
    '{OP_TICK, 16'h0000, 8'h00, 8'h00, 1,   1'b1, R_IDLE},
    '{OP_SEND, 16'hFFFF, 8'hFF, 8'hFF, 1,   1'b1, R_TAKEN},
    '{OP_SEND, 16'h1234, 8'h56, 8'h78, 1,   1'b1, R_REFUSED},
    '{OP_TICK, 16'h0000, 8'h00, 8'h00, 183, 1'b0, R_IDLE},
    '{OP_TICK, 16'hFFFF, 8'hFF, 8'hFF, 1,   1'b1, R_LAST},
    '{OP_TICK, 16'h0000, 8'h00, 8'h00, 1,   1'b1, R_IDLE}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_opcode;
  logic [15:0] in_remote_id;
  logic [7:0]  in_channel_number;
  logic [7:0]  in_action_code;
  logic        out_valid;
  logic        out_stall;
  logic        out_line_level;
  logic        out_busy_res;
  logic        out_accepted;
  logic        out_frame_done;

  manchester_frame_transmitter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_remote_id      (in_remote_id),
    .in_channel_number (in_channel_number),
    .in_action_code    (in_action_code),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_line_level    (out_line_level),
    .out_busy_res      (out_busy_res),
    .out_accepted      (out_accepted),
    .out_frame_done    (out_frame_done)
  );

  // Predictor state.
  logic [DATA_BITS-1:0] pend_bits;
  logic [5:0]           seg_q;
  logic [3:0]           tick_q;
  logic [5:0]           bit_q;
  logic                 half_q;
  logic                 busy_q;
  logic                 data_q;
  logic                 level_q;

  tx_result_t line_results_q [$];
  int         err_cnt = 0;
  int         results_seen = 0;
  int         cycle_cnt = 0;
  bit         tx_calm = 1'b0;
  bit         rx_calm = 1'b0;

  function automatic tx_result_t advance_line(input opcode_t op, input logic [15:0] rem,
                                              input logic [7:0] ch, input logic [7:0] act);
    tx_result_t r;
    logic [7:0] sum;
    logic [5:0] seg;
    logic [5:0] idx;
    logic [3:0] seg_len;
    logic       bit_val;
    r = '{level_q, 1'b0, 1'b0, 1'b0};
    if (op == OP_SEND) begin
      if (!busy_q) begin
        sum = ch + rem[7:0] + rem[15:8] + act + CHECK_OFFSET;
        pend_bits = {2'b00, sum, act, rem[15:8], rem[7:0], ch, 1'b0};
        seg_q = '0;
        tick_q = '0;
        bit_q = '0;
        half_q = 1'b0;
        data_q = 1'b0;
        busy_q = 1'b1;
        r.acc = 1'b1;
      end
    end else if (busy_q) begin
      if (!data_q) begin
        seg = (seg_q >= HDR_SEGMENTS) ? 6'(HDR_SEGMENTS - 1) : seg_q;
        if (seg < 2 * HDR_PAIRS) begin
          r.level = seg[0];
        end else begin
          r.level = (seg == 2 * HDR_PAIRS + 1);
        end
        seg_len = (seg <= 2 * HDR_PAIRS) ? SHORT_TICKS : LONG_TICKS;
        tick_q = tick_q + 4'd1;
        if (tick_q >= seg_len) begin
          tick_q = '0;
          seg_q = seg + 6'd1;
          if (seg_q >= HDR_SEGMENTS) begin
            seg_q = '0;
            data_q = 1'b1;
            bit_q = '0;
            half_q = 1'b0;
          end
        end
      end else begin
        idx = (bit_q >= DATA_BITS) ? 6'(DATA_BITS - 1) : bit_q;
        bit_val = pend_bits[idx];
        // Manchester: a one goes low then high, a zero high then low.
        r.level = half_q ? bit_val : ~bit_val;
        if (!half_q) begin
          half_q = 1'b1;
        end else begin
          half_q = 1'b0;
          bit_q = idx + 6'd1;
          if (bit_q >= DATA_BITS) begin
            bit_q = '0;
            busy_q = 1'b0;
            data_q = 1'b0;
            r.done = 1'b1;
          end
        end
      end
      level_q = r.level;
    end
    r.busy = busy_q;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic got, input logic exp);
    $display("mismatch at result %0d: %s got %0b expected %0b", results_seen, what, got, exp);
    err_cnt++;
  endtask

  // Called at a rising edge; returns at the edge where the transaction is taken.
  task automatic offer(input opcode_t op, input logic [15:0] rem, input logic [7:0] ch,
                       input logic [7:0] act, input bit typed, input tx_result_t want);
    int gap;
    tx_result_t predicted;
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_remote_id <= rem;
    in_channel_number <= ch;
    in_action_code <= act;
    do @(negedge clk); while (in_stall);
    predicted = advance_line(op, rem, ch, act);
    line_results_q.push_back(typed ? want : predicted);
    @(posedge clk);
  endtask

  task automatic offer_random(input opcode_t op);
    offer(op, 16'($urandom), 8'($urandom), 8'($urandom), 1'b0, R_IDLE);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int kind;
    int refuse_at;
    int burst;
    int rand_items;
    rand_items = 0;
    pend_bits = '0;
    seg_q = '0;
    tick_q = '0;
    bit_q = '0;
    half_q = 1'b0;
    busy_q = 1'b0;
    data_q = 1'b0;
    level_q = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_opcode <= OP_TICK;
    in_remote_id <= '0;
    in_channel_number <= '0;
    in_action_code <= '0;
    out_stall <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      for (int k = 0; k < plan[i].reps; k++) begin
        offer(plan[i].op, plan[i].rem, plan[i].ch, plan[i].act, plan[i].typed, plan[i].want);
      end
    end

    // Let the block drain completely before the random part.
    in_valid <= 1'b0;
    do @(posedge clk); while (line_results_q.size() != 0);

    while (rand_items < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        // A frame, sometimes with a refused send inside it; the last may be cut short.
        refuse_at = ($urandom_range(0, 1) != 0) ? $urandom_range(0, FRAME_TICKS - 1) : -1;
        offer_random(OP_SEND);
        rand_items++;
        for (int t = 0; t < FRAME_TICKS && rand_items < RANDOM_ITEMS; t++) begin
          if (t == refuse_at) begin
            offer_random(OP_SEND);
            rand_items++;
          end
          offer_random(OP_TICK);
          rand_items++;
        end
      end else begin
        burst = $urandom_range(1, 20);
        repeat (burst) offer_random(($urandom_range(0, 3) == 0) ? OP_SEND : OP_TICK);
        rand_items += burst;
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (line_results_q.size() != 0);
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    int hold;
    tx_result_t seen;
    tx_result_t want;
    do @(negedge clk); while (!rst_n);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      hold = rx_calm ? 0 : $urandom_range(0, 15);
      // One long hold-off so that the block fills up and stalls its input.
      if (results_seen == HOLD_AT_RESULT) hold = LONG_HOLD;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(negedge clk); while (!out_valid);
      seen = '{out_line_level, out_busy_res, out_accepted, out_frame_done};
      if (line_results_q.size() == 0) begin
        flag_mismatch("unexpected transaction, valid", 1'b1, 1'b0);
      end else begin
        want = line_results_q.pop_front();
        if (seen.level !== want.level) flag_mismatch("line_level", seen.level, want.level);
        if (seen.busy !== want.busy) flag_mismatch("busy_res", seen.busy, want.busy);
        if (seen.acc !== want.acc) flag_mismatch("accepted", seen.acc, want.acc);
        if (seen.done !== want.done) flag_mismatch("frame_done", seen.done, want.done);
      end
      results_seen++;
      @(posedge clk);
    end
  end

endmodule
